@@ sv/lpcmu_pkg.sv @@
// Shared types and constants of the LPCM sample unpacker.
package lpcmu_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int STORE_DEPTH  = 8 * MAX_CHANNELS;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int FILL_W       = ADDR_W + 1;

   // configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_BLURAY_MODE   = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd2;

   typedef enum logic [1:0] {
      FMT_16 = 2'd0,
      FMT_20 = 2'd1,
      FMT_24 = 2'd2,
      FMT_32 = 2'd3
   } fmt_type;

   typedef struct packed {
      fmt_type    sample_format;
      logic       bluray_mode;
      logic [3:0] channel_count;
   } cfg_type;

   // one completed group (or one rejected byte) waiting for the back end
   typedef struct packed {
      logic is_error;
      logic bank;
   } job_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic              bank;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

endpackage

@@ sv/lpcmu_store.sv @@
// Two-bank group store: one write port, one registered read port.
module lpcmu_store (
   input  logic                  clock,
   input  lpcmu_pkg::store_wr_type wr,
   input  lpcmu_pkg::store_rd_type rd,
   output logic [7:0]            rd_data
);
   import lpcmu_pkg::*;

   logic [7:0] mem [2*STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.addr}] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[{rd.bank, rd.addr}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lpcmu_queue.sv @@
// Two-entry job queue between the collecting front end and the emitting back end.
module lpcmu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpcmu_pkg::job_type push_job,
   input  logic               pop,
   output lpcmu_pkg::job_type head_job,
   output logic               empty,
   output logic               full
);
   import lpcmu_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule

@@ sv/lpcmu_front.sv @@
// Front end: collect input bytes into the store and hand off completed groups.
module lpcmu_front (
   input  logic                    clock,
   input  logic                    reset,
   input  lpcmu_pkg::cfg_type      cfg,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    end_of_frame,
   output logic                    push,
   output lpcmu_pkg::job_type      push_job,
   output lpcmu_pkg::store_wr_type wr
);
   import lpcmu_pkg::*;

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              bank_ff, bank_in;
   logic [FILL_W-1:0] c_ext;
   logic [FILL_W-1:0] gsize;
   logic              cfg_bad;
   logic [ADDR_W-1:0] eff_fill;
   logic [FILL_W-1:0] next_fill;
   logic              done;

   always_comb begin
      c_ext = FILL_W'(cfg.channel_count);
      if (cfg.bluray_mode) begin
         unique case (cfg.sample_format)
            FMT_16:  gsize = c_ext << 1;
            FMT_24:  gsize = (c_ext << 1) + c_ext;
            FMT_20,
            FMT_32:  gsize = c_ext << 2;
            default: gsize = c_ext << 2;
         endcase
      end else begin
         unique case (cfg.sample_format)
            FMT_16:  gsize = c_ext << 1;
            FMT_20:  gsize = (c_ext << 2) + c_ext;
            FMT_24:  gsize = (c_ext << 2) + (c_ext << 1);
            FMT_32:  gsize = c_ext << 3;
            default: gsize = c_ext << 3;
         endcase
      end

      cfg_bad = (cfg.channel_count == 4'd0)
             || (cfg.channel_count > 4'(MAX_CHANNELS))
             || ((cfg.sample_format == FMT_20)
                 && (cfg.bluray_mode || cfg.channel_count[0]));

      // a partial group left over from a larger group size restarts
      eff_fill  = ({1'b0, fill_ff} >= gsize) ? '0 : fill_ff;
      next_fill = {1'b0, eff_fill} + FILL_W'(1);
      done      = (next_fill == gsize);

      push              = 1'b0;
      push_job.is_error = cfg_bad;
      push_job.bank     = bank_ff;
      wr.en             = 1'b0;
      wr.bank           = bank_ff;
      wr.addr           = eff_fill;
      wr.data           = data_byte;
      fill_in           = fill_ff;
      bank_in           = bank_ff;

      if (accept) begin
         if (cfg_bad) begin
            push    = 1'b1;
            fill_in = '0;
         end else begin
            wr.en = 1'b1;
            if (done) begin
               push    = 1'b1;
               fill_in = '0;
               bank_in = ~bank_ff;
            end else if (end_of_frame) begin
               fill_in = '0;
            end else begin
               fill_in = next_fill[ADDR_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
      end
   end

endmodule

@@ sv/lpcmu_back.sv @@
// Back end: walk the head group in output order, read the store, drive results.
module lpcmu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lpcmu_pkg::cfg_type      cfg,
   input  logic                    head_valid,
   input  lpcmu_pkg::job_type      head_job,
   output logic                    pop,
   output lpcmu_pkg::store_rd_type rd,
   input  logic [7:0]              rd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_group_last,
   output logic                    rsp_config_error
);
   import lpcmu_pkg::*;

   localparam logic [7:0] HIGH_NIBBLE  = 8'hf0;
   localparam int         NIBBLE_SHIFT = 4;

   typedef enum logic [1:0] {
      OP_COPY,
      OP_NIB_HI,
      OP_NIB_LO,
      OP_ERROR
   } op_type;

   // source channel that lands in output slot s (Blu-ray channel order)
   function automatic logic [2:0] br_src_chan(input logic [3:0] c, input logic [2:0] s);
      logic [2:0] k;
      k = s;
      if (c == 4'd6) begin
         if (s == 3'd3) k = 3'd5;
         if (s == 3'd4) k = 3'd3;
         if (s == 3'd5) k = 3'd4;
      end else if (c == 4'd7) begin
         if (s == 3'd3) k = 3'd6;
         if (s == 3'd4) k = 3'd3;
         if (s == 3'd6) k = 3'd4;
      end else if (c == 4'd8) begin
         if (s == 3'd3) k = 3'd7;
         if (s == 3'd4) k = 3'd3;
         if (s == 3'd5) k = 3'd6;
         if (s == 3'd6) k = 3'd4;
         if (s == 3'd7) k = 3'd5;
      end
      return k;
   endfunction

   logic [3:0]        j_ff, j_in;
   logic [2:0]        p_ff, p_in;
   logic              mid_valid_ff, mid_valid_in;
   op_type            mid_op_ff, mid_op_in;
   logic              mid_last_ff, mid_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_error_ff, out_error_in;

   logic [2:0]        sw;          // bytes per step of the output walk
   logic [3:0]        j_last;      // index of the last walk step
   logic [4:0]        two_c;
   logic              last;
   logic              move;
   logic              issue;
   logic [ADDR_W-1:0] j6, c4, addr;
   logic [2:0]        kin;
   logic [ADDR_W-1:0] k6;
   op_type            op;

   always_comb begin
      two_c = {cfg.channel_count, 1'b0};
      j6    = ADDR_W'(j_ff);
      c4    = ADDR_W'({cfg.channel_count, 2'b00});
      kin   = br_src_chan(cfg.channel_count, j_ff[2:0]);
      k6    = ADDR_W'(kin);
      op    = OP_COPY;
      addr  = '0;

      if (cfg.bluray_mode) begin
         unique case (cfg.sample_format)
            FMT_16:  sw = 3'd2;
            FMT_24:  sw = 3'd3;
            FMT_20,
            FMT_32:  sw = 3'd4;
            default: sw = 3'd4;
         endcase
         j_last = cfg.channel_count - 4'd1;
         unique case (sw)
            3'd2:    addr = (k6 << 1) + ADDR_W'(3'd1 - p_ff);
            3'd3:    addr = (k6 << 1) + k6 + ADDR_W'(3'd2 - p_ff);
            default: addr = (k6 << 2) + ADDR_W'(3'd3 - p_ff);
         endcase
      end else begin
         unique case (cfg.sample_format)
            FMT_16: begin
               sw     = 3'd2;
               j_last = cfg.channel_count - 4'd1;
               addr   = (j6 << 1) + ADDR_W'(p_ff == 3'd0);
            end
            FMT_20: begin
               sw     = 3'd6;
               j_last = cfg.channel_count - 4'd1;
               unique case (p_ff)
                  3'd0: begin addr = c4 + j6; op = OP_NIB_HI; end
                  3'd1: addr = (j6 << 2) + ADDR_W'(1);
                  3'd2: addr = (j6 << 2);
                  3'd3: begin addr = c4 + j6; op = OP_NIB_LO; end
                  3'd4: addr = (j6 << 2) + ADDR_W'(3);
                  default: addr = (j6 << 2) + ADDR_W'(2);
               endcase
            end
            FMT_24: begin
               sw     = 3'd3;
               j_last = 4'(two_c - 5'd1);
               unique case (p_ff)
                  3'd0:    addr = c4 + j6;
                  3'd1:    addr = (j6 << 1) + ADDR_W'(1);
                  default: addr = (j6 << 1);
               endcase
            end
            default: begin
               sw     = 3'd4;
               j_last = 4'(two_c - 5'd1);
               unique case (p_ff)
                  3'd0:    addr = c4 + (j6 << 1) + ADDR_W'(1);
                  3'd1:    addr = c4 + (j6 << 1);
                  3'd2:    addr = (j6 << 1) + ADDR_W'(1);
                  default: addr = (j6 << 1);
               endcase
            end
         endcase
      end

      if (head_job.is_error) begin
         op = OP_ERROR;
      end

      last  = (j_ff == j_last) && (p_ff == sw - 3'd1);
      move  = mid_valid_ff && (!out_valid_ff || !rsp_stall);
      issue = head_valid && (!mid_valid_ff || move);
      pop   = issue && (head_job.is_error || last);

      rd.en   = issue && !head_job.is_error;
      rd.bank = head_job.bank;
      rd.addr = addr;

      // advance the output walk
      j_in = j_ff;
      p_in = p_ff;
      if (issue && !head_job.is_error) begin
         if (last) begin
            j_in = '0;
            p_in = '0;
         end else if (p_ff == sw - 3'd1) begin
            j_in = j_ff + 4'd1;
            p_in = '0;
         end else begin
            p_in = p_ff + 3'd1;
         end
      end

      mid_valid_in = issue ? 1'b1 : (move ? 1'b0 : mid_valid_ff);
      mid_op_in    = issue ? op : mid_op_ff;
      mid_last_in  = issue ? (last && !head_job.is_error) : mid_last_ff;

      out_valid_in = move ? 1'b1 : (out_valid_ff && rsp_stall);
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      if (move) begin
         out_last_in  = mid_last_ff;
         out_error_in = (mid_op_ff == OP_ERROR);
         unique case (mid_op_ff)
            OP_COPY:   out_byte_in = rd_data;
            OP_NIB_HI: out_byte_in = rd_data & HIGH_NIBBLE;
            OP_NIB_LO: out_byte_in = 8'(rd_data << NIBBLE_SHIFT);
            default:   out_byte_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff         <= '0;
         p_ff         <= '0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         j_ff         <= j_in;
         p_ff         <= p_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_op_ff    <= mid_op_in;
      mid_last_ff  <= mid_last_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_group_last   = out_last_ff;
   assign rsp_config_error = out_error_ff;

endmodule

@@ sv/lpcm_sample_unpacker.sv @@
// Top level of the LPCM sample unpacker: configuration registers and the front/queue/back chain.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    data_byte[8], end_of_frame[1]
//   rsp_      out        rsp_valid/stall    out_byte[8], group_last[1], config_error[1]
//   csr_      in         csr_wr_en          csr_index[2], csr_wr_data[4]
//
// Input bytes are taken one per cycle while req_stall is low and written into one
// bank of a two-bank group store. A completed group (or a rejected byte) becomes a
// job in a two-entry queue; req_stall rises only while both entries are occupied.
// The back end emits one result per cycle while rsp_stall is low, from the store's
// single read port; each byte passes the store's read register and the output register.
// Reset is synchronous: it restores the register defaults and clears the fill
// count, queue and pipeline. The store has no reset and needs no clearing pass.
module lpcm_sample_unpacker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_group_last,
   output logic       rsp_config_error,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wr_data
);
   import lpcmu_pkg::*;

   fmt_type      sample_format_ff;
   logic         bluray_mode_ff;
   logic [3:0]   channel_count_ff;
   cfg_type      cfg;

   logic         accept;
   logic         push;
   job_type      push_job;
   logic         pop;
   job_type      head_job;
   logic         q_empty;
   logic         q_full;
   store_wr_type wr;
   store_rd_type rd;
   logic [7:0]   rd_data;

   // configuration registers; an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= FMT_16;
         bluray_mode_ff   <= 1'b0;
         channel_count_ff <= 4'd2;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SAMPLE_FORMAT) begin
            sample_format_ff <= fmt_type'(csr_wr_data[1:0]);
         end
         if (csr_index == CSR_BLURAY_MODE) begin
            bluray_mode_ff <= csr_wr_data[0];
         end
         if (csr_index == CSR_CHANNEL_COUNT) begin
            channel_count_ff <= csr_wr_data;
         end
      end
   end

   assign cfg.sample_format = sample_format_ff;
   assign cfg.bluray_mode   = bluray_mode_ff;
   assign cfg.channel_count = channel_count_ff;

   // hold the input while both queue entries are taken
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   lpcmu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .end_of_frame (req_end_of_frame),
      .push         (push),
      .push_job     (push_job),
      .wr           (wr)
   );

   lpcmu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   lpcmu_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   lpcmu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (!q_empty),
      .head_job         (head_job),
      .pop              (pop),
      .rd               (rd),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_config_error (rsp_config_error)
   );

endmodule

@@ tb/sv/lpcmu_checker.sv @@
// Scoreboard for the LPCM unpacker: tracks register writes, predicts every output byte, compares.
module lpcmu_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_frame,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_group_last,
   input  logic       rsp_config_error,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wr_data,
   output int         mismatches,
   output int         pending,
   output int         results_seen,
   output int         groups_seen,
   output int         rejects_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import lpcmu_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } pcm_byte_type;

   logic [7:0] group_bytes [STORE_DEPTH];
   int unsigned  fill = 0;
   fmt_type      fmt = FMT_16;
   logic         br = 1'b0;
   logic [3:0]   chans = 4'd2;
   pcm_byte_type byte_queue [$];

   int mismatch_total = 0;
   int queued = 0;
   int result_total = 0;
   int group_total = 0;
   int reject_total = 0;

   assign mismatches   = mismatch_total;
   assign pending      = queued;
   assign results_seen = result_total;
   assign groups_seen  = group_total;
   assign rejects_seen = reject_total;

   function automatic bit combo_rejected();
      return chans == 4'd0 || chans > MAX_CHANNELS || (fmt == FMT_20 && (br || chans[0]));
   endfunction

   function automatic int unsigned sample_width();
      return (fmt == FMT_16) ? 2 : (fmt == FMT_24) ? 3 : 4;
   endfunction

   // input bytes that make up one packing group
   function automatic int unsigned collect_length();
      int unsigned c;
      c = chans;
      if (br) return c * sample_width();
      case (fmt)
         FMT_16:  return 2 * c;
         FMT_20:  return 5 * c;
         FMT_24:  return 6 * c;
         default: return 8 * c;
      endcase
   endfunction

   // reorder the collected group into little-endian samples and queue them
   function automatic void queue_group();
      logic [7:0]  ob [STORE_DEPTH];
      int unsigned slot [MAX_CHANNELS];
      int unsigned c, w, n, k, b, j;
      logic [7:0]  nib;
      c = chans;
      w = sample_width();
      n = 0;
      for (k = 0; k < STORE_DEPTH; k++) ob[k] = 8'h00;
      if (br) begin
         // surround channels move behind the center/LFE pair
         for (k = 0; k < MAX_CHANNELS; k++) slot[k] = k;
         if (c > 5) begin
            slot[(c - 1) & 7] = 3;
            slot[3] = 4;
            slot[(c - 2) & 7] = 5;
         end
         if (c > 6) slot[4] = 6;
         if (c > 7) slot[5] = 7;
         for (k = 0; k < c; k++)
            for (b = 0; b < w; b++)
               ob[(slot[k] * w + w - 1 - b) % STORE_DEPTH] = group_bytes[k * w + b];
         n = c * w;
      end else begin
         case (fmt)
            FMT_16: begin
               for (j = 0; j < c; j++) begin
                  ob[2 * j]     = group_bytes[2 * j + 1];
                  ob[2 * j + 1] = group_bytes[2 * j];
               end
               n = 2 * c;
            end
            FMT_20: begin
               // low nibbles of each sample pair sit after the 16-bit words
               for (j = 0; j < c; j++) begin
                  nib           = group_bytes[4 * c + j];
                  ob[6 * j]     = nib & 8'hf0;
                  ob[6 * j + 1] = group_bytes[4 * j + 1];
                  ob[6 * j + 2] = group_bytes[4 * j];
                  ob[6 * j + 3] = {nib[3:0], 4'h0};
                  ob[6 * j + 4] = group_bytes[4 * j + 3];
                  ob[6 * j + 5] = group_bytes[4 * j + 2];
               end
               n = 6 * c;
            end
            FMT_24: begin
               for (j = 0; j < 2 * c; j++) begin
                  ob[3 * j]     = group_bytes[4 * c + j];
                  ob[3 * j + 1] = group_bytes[2 * j + 1];
                  ob[3 * j + 2] = group_bytes[2 * j];
               end
               n = 6 * c;
            end
            default: begin
               for (j = 0; j < 2 * c; j++) begin
                  ob[4 * j]     = group_bytes[4 * c + 2 * j + 1];
                  ob[4 * j + 1] = group_bytes[4 * c + 2 * j];
                  ob[4 * j + 2] = group_bytes[2 * j + 1];
                  ob[4 * j + 3] = group_bytes[2 * j];
               end
               n = 8 * c;
            end
         endcase
      end
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      for (k = 0; k < n; k++)
         byte_queue.push_back('{data: ob[k], last: (k + 1 == n), err: 1'b0});
   endfunction

   always @(posedge clock) begin : watch
      pcm_byte_type want;
      if (reset) begin
         fmt   = FMT_16;
         br    = 1'b0;
         chans = 4'd2;
         fill  = 0;
         byte_queue.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (combo_rejected()) begin
               fill = 0;
               byte_queue.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
            end else begin
               if (fill >= collect_length()) fill = 0;
               group_bytes[fill] = req_data_byte;
               fill++;
               if (fill < collect_length()) begin
                  if (req_end_of_frame) fill = 0;
               end else begin
                  fill = 0;
                  queue_group();
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_FORMAT: fmt   = fmt_type'(csr_wr_data[1:0]);
               CSR_BLURAY_MODE:   br    = csr_wr_data[0];
               CSR_CHANNEL_COUNT: chans = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_total++;
            if (rsp_group_last === 1'b1) group_total++;
            if (rsp_config_error === 1'b1) reject_total++;
            if (byte_queue.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: unexpected output byte %02h last %b err %b", $realtime,
                           rsp_out_byte, rsp_group_last, rsp_config_error);
               mismatch_total++;
            end else begin
               want = byte_queue.pop_front();
               if (rsp_out_byte !== want.data || rsp_group_last !== want.last ||
                   rsp_config_error !== want.err) begin
                  if (mismatch_total < 10)
                     $display("%0t: mismatch, want byte %02h last %b err %b, got %02h %b %b",
                              $realtime, want.data, want.last, want.err,
                              rsp_out_byte, rsp_group_last, rsp_config_error);
                  mismatch_total++;
               end
            end
         end
      end
      queued = byte_queue.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the LPCM sample unpacker: clock, reset, stimulus, flow control, verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lpcmu_pkg::*;

   localparam int RANDOM_ITEMS  = 280;
   localparam int HOLD_CYCLES   = 400;    // receiver hold-off used to back up the job queue
   localparam int SETTLE_CYCLES = 8;      // margin for the back-end pipeline to empty
   localparam int CYCLE_LIMIT   = 400000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_end_of_frame;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_group_last;
   logic       rsp_config_error;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [3:0] csr_wr_data;

   int mismatches, pending, results_seen, groups_seen, rejects_seen;
   int items_sent    = 0;
   int settings_made = 0;
   int cycle_count   = 0;

   // shared flow-control knobs: steady turns off idling on both sides,
   // long_hold asks the receiver for one long stall stretch
   bit steady      = 1'b0;
   bit long_hold   = 1'b0;
   bit hold_active = 1'b0;

   // shadow of the register settings, used only to shape stimulus
   fmt_type    cur_fmt   = FMT_16;
   logic       cur_br    = 1'b0;
   logic [3:0] cur_chans = 4'd2;

   lpcm_sample_unpacker dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_config_error (rsp_config_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   lpcmu_checker unpack_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_group_last   (rsp_group_last),
      .rsp_config_error (rsp_config_error),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .pending          (pending),
      .results_seen     (results_seen),
      .groups_seen      (groups_seen),
      .rejects_seen     (rejects_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d output bytes still outstanding",
                  cycle_count, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Idle length: mostly short, now and then long.
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Input bytes per group for the current setting; zero means the setting is rejected.
   function automatic int unsigned bytes_per_group();
      int unsigned c;
      c = cur_chans;
      if (c == 0 || c > MAX_CHANNELS) return 0;
      if (cur_fmt == FMT_20 && (cur_br || cur_chans[0])) return 0;
      if (cur_br) return c * ((cur_fmt == FMT_16) ? 2 : (cur_fmt == FMT_24) ? 3 : 4);
      case (cur_fmt)
         FMT_16:  return 2 * c;
         FMT_20:  return 5 * c;
         FMT_24:  return 6 * c;
         default: return 8 * c;
      endcase
   endfunction

   // Receiver: alternate ready runs and stall stretches; honor a long hold-off
   // when asked, counting it here so the sender keeps pushing meanwhile.
   initial begin : receiver
      bit          seg_stall;
      int unsigned seg_left;
      seg_stall = 1'b0;
      seg_left  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold   = 1'b0;
            hold_active = 1'b0;
            seg_stall   = 1'b0;
            seg_left    = 0;
         end else begin
            if (seg_left == 0) begin
               seg_stall = !steady && !seg_stall && ($urandom_range(0, 99) < 45);
               seg_left  = seg_stall ? gap_len() : $urandom_range(1, 12);
            end
            rsp_stall <= seg_stall;
            seg_left--;
         end
      end
   end

   // Offer one item, hold it until accepted, then maybe idle the input.
   task automatic send_byte(input logic [7:0] d, input logic e);
      int unsigned gap;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_end_of_frame <= e;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = steady ? 0 : (($urandom_range(0, 99) < 60) ? 0 : gap_len());
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Send a run of random bytes; only the last one may carry the frame-end flag.
   task automatic send_random(input int unsigned len, input logic eof_last);
      int unsigned i;
      for (i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), (i == len - 1) ? eof_last : 1'b0);
   endtask

   // Drop valid, drain every outstanding output byte, then let the pipeline empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Reprogram all three registers while the block is idle.
   task automatic set_config(input fmt_type f, input logic b, input logic [3:0] c);
      settle();
      write_reg(CSR_SAMPLE_FORMAT, {2'b00, f});
      write_reg(CSR_BLURAY_MODE, {3'b000, b});
      write_reg(CSR_CHANNEL_COUNT, c);
      cur_fmt   = f;
      cur_br    = b;
      cur_chans = c;
      settings_made++;
   endtask

   initial begin : stimulus
      int unsigned start_items, phase, gsize, n, r;
      fmt_type     f;
      logic        b;
      logic [3:0]  c;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_end_of_frame = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_SAMPLE_FORMAT;
      csr_wr_data      = 4'h0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: 16-bit DVD stereo, so four bytes make a group of swapped pairs.
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      send_byte(8'ha5, 1'b0);
      // Frame ends halfway through a group: drop the partial group, no output.
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);

      // 20-bit DVD stereo: eight word bytes then two nibble bytes, expanded to twelve.
      set_config(FMT_20, 1'b0, 4'd2);
      send_byte(8'h01, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h84, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hfe, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h3c, 1'b0);

      // 32-bit Blu-ray mono, frame-end on the completing byte: group still comes out.
      set_config(FMT_32, 1'b1, 4'd1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);

      // 20-bit with an odd channel count is unsupported: one error byte per input.
      set_config(FMT_20, 1'b0, 4'd1);
      send_byte(8'hff, 1'b0);

      // Leave three bytes of a stereo group, then shrink the group under them:
      // the stale partial group is discarded and the next byte starts afresh.
      set_config(FMT_16, 1'b0, 4'd2);
      send_byte(8'hc3, 1'b0);
      send_byte(8'h3c, 1'b0);
      send_byte(8'h96, 1'b0);
      set_config(FMT_16, 1'b0, 4'd1);
      send_byte(8'h69, 1'b0);
      send_byte(8'he1, 1'b0);

      // Back-pressure: receiver stalls for a long stretch while small groups keep
      // arriving back to back, so the job queue fills and the input stalls.
      set_config(FMT_16, 1'b0, 4'd1);
      steady    = 1'b1;
      long_hold = 1'b1;
      wait (hold_active);
      send_random(40, 1'b0);
      steady = 1'b0;

      // Random phases: the first few pin the widest and remapped settings,
      // the rest pick settings at random, a few of them unsupported.
      start_items = items_sent;
      phase = 0;
      while (items_sent - start_items < RANDOM_ITEMS) begin
         case (phase)
            0: begin f = FMT_24; b = 1'b1; c = 4'd8; end
            1: begin f = FMT_32; b = 1'b0; c = 4'd8; end
            2: begin f = FMT_16; b = 1'b1; c = 4'd7; end
            3: begin f = FMT_20; b = 1'b0; c = 4'd8; end
            4: begin f = FMT_32; b = 1'b1; c = 4'd6; end
            default: begin
               if ($urandom_range(0, 99) < 10) begin
                  f = fmt_type'($urandom_range(0, 3));
                  b = 1'($urandom_range(0, 1));
                  case ($urandom_range(0, 3))
                     0: begin f = FMT_20; b = 1'b1; c = 4'(2 * $urandom_range(1, 4)); end
                     1: begin f = FMT_20; b = 1'b0; c = 4'(2 * $urandom_range(0, 3) + 1); end
                     2: c = 4'd0;
                     default: c = 4'($urandom_range(9, 15));
                  endcase
               end else begin
                  f = fmt_type'($urandom_range(0, 3));
                  b = (f == FMT_20) ? 1'b0 : 1'($urandom_range(0, 1));
                  c = 4'(($urandom_range(0, 99) < 60) ? $urandom_range(1, 3)
                                                      : $urandom_range(1, 8));
                  if (f == FMT_20 && c[0]) c = c + 4'd1;
               end
            end
         endcase
         steady = ($urandom_range(0, 99) < 25);
         set_config(f, b, c);
         gsize = bytes_per_group();
         if (gsize == 0) begin
            n = $urandom_range(3, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            // keep settings of more than 32 bytes per group to a single group
            n = (gsize > 32) ? 1 : $urandom_range(1, 3);
            repeat (n) begin
               r = $urandom_range(0, 99);
               if (r < 15)
                  send_random($urandom_range(1, gsize - 1), 1'b1);
               else if (r < 25)
                  send_byte(8'($urandom_range(0, 255)), 1'b1);
               else
                  send_random(gsize, 1'($urandom_range(0, 99) < 30));
            end
            // sometimes leave a partial group for the next setting to inherit
            if ($urandom_range(0, 99) < 30)
               send_random($urandom_range(1, gsize - 1), 1'b0);
         end
         phase++;
      end
      steady = 1'b0;

      settle();
      $display("covered %0d input items and %0d output bytes: %0d groups, %0d rejected bytes",
               items_sent, results_seen, groups_seen, rejects_seen);
      $display("covered %0d register settings and a %0d-cycle receiver hold-off",
               settings_made, HOLD_CYCLES);
      if (mismatches == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ lpcm_sample_unpacker.f @@
sv/lpcmu_pkg.sv
sv/lpcmu_store.sv
sv/lpcmu_queue.sv
sv/lpcmu_front.sv
sv/lpcmu_back.sv
sv/lpcm_sample_unpacker.sv
tb/sv/lpcmu_checker.sv
tb/sv/tb_top.sv
